// ===== rtl/core/bcd_pkg.sv =====
`default_nettype none

package bcd_pkg;

  localparam int unsigned NUM_WAYS    = 3;
  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned ADDR_BITS   = 24;

  localparam int unsigned OFFSET_W = $clog2(BLOCK_BYTES);
  localparam int unsigned TAG_W    = ADDR_BITS - OFFSET_W;
  localparam int unsigned WAY_W    = $clog2(NUM_WAYS);
  localparam int unsigned COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_ONE = 16'h0001;

  localparam int unsigned IN_DATA_W    = ((ADDR_BITS + 7) / 8) * 8;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_FIELDS_W = WAY_W + OFFSET_W + TAG_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;
  localparam int unsigned OUT_USER_W   = 2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } bcd_state_t;

  typedef struct packed {
    logic load;
    logic commit;
  } bcd_cmd_t;

  function automatic logic [TAG_W-1:0] reset_tag(input int unsigned w);
    logic [TAG_W-1:0] t;
    unique case (w)
      1: t = TAG_W'(6552);
      2: t = TAG_W'(3011);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [COUNT_W-1:0] reset_count(input int unsigned w);
    logic [COUNT_W-1:0] c;
    unique case (w)
      0: c = COUNT_MAX;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/block_cache_directory.sv =====
// an accepted item is registered, looked up, and its result taken into the result register behind out_tvalid
// throughput: one item per cycle while results drain; the lookup of an item runs against the
//   tag, count and dirty registers once the item is registered and updates them at its end
// reset: synchronous, active low; the directory loads its boot tags and counts with every way
//   dirty, and the channels come up empty
`default_nettype none

module block_cache_directory
  import bcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // byte_address
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // is_fetch, is_write
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // way, offset_in_block, writeback_block, zeros
  output logic [OUT_USER_W-1:0]      out_tuser   // hit, writeback_needed
);

  bcd_cmd_t            cmd;
  logic                res_hit;
  logic [WAY_W-1:0]    res_way;
  logic [OFFSET_W-1:0] res_offset;
  logic                res_wb_need;
  logic [TAG_W-1:0]    res_wb_block;

  bcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd)
  );

  bcd_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .req_addr     (in_tdata[ADDR_BITS-1:0]),
    .req_fetch    (in_tuser[0]),
    .req_write    (in_tuser[1]),
    .res_hit      (res_hit),
    .res_way      (res_way),
    .res_offset   (res_offset),
    .res_wb_need  (res_wb_need),
    .res_wb_block (res_wb_block)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_wb_block, res_offset, res_way};
  assign out_tuser = {res_wb_need, res_hit};

endmodule

`default_nettype wire

// ===== rtl/core/bcd_datapath.sv =====
`default_nettype none

module bcd_datapath
  import bcd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire bcd_cmd_t              cmd,
  input  wire logic [ADDR_BITS-1:0]  req_addr,
  input  wire logic                  req_fetch,
  input  wire logic                  req_write,
  output logic                       res_hit,
  output logic [WAY_W-1:0]           res_way,
  output logic [OFFSET_W-1:0]        res_offset,
  output logic                       res_wb_need,
  output logic [TAG_W-1:0]           res_wb_block
);

  logic [ADDR_BITS-1:0] addr_r;
  logic                 fetch_r;
  logic                 write_r;

  logic [TAG_W-1:0]   tag_r   [NUM_WAYS];
  logic [COUNT_W-1:0] cnt_r   [NUM_WAYS];
  logic               dirty_r [NUM_WAYS];

  logic                hit_r;
  logic [WAY_W-1:0]    way_r;
  logic [OFFSET_W-1:0] off_r;
  logic                wb_need_r;
  logic [TAG_W-1:0]    wb_blk_r;

  logic [TAG_W-1:0]    blk;
  logic                hit;
  logic [WAY_W-1:0]    hit_way;
  logic                fetch_found;
  logic [WAY_W-1:0]    fetch_vic;
  logic [WAY_W-1:0]    data_vic;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    sel;

  assign blk = addr_r[ADDR_BITS-1:OFFSET_W];

  always_comb begin
    hit         = 1'b0;
    hit_way     = '0;
    fetch_found = 1'b0;
    fetch_vic   = WAY_W'(NUM_WAYS - 1);
    data_vic    = WAY_W'(NUM_WAYS - 1);
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && tag_r[w] == blk) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    // pinned way: first full count among all but the last way
    for (int w = 0; w < NUM_WAYS - 1; w++) begin
      if (!fetch_found && cnt_r[w] == COUNT_MAX) begin
        fetch_found = 1'b1;
        fetch_vic   = WAY_W'(w);
      end
    end
    // smallest count, ties to the higher way
    for (int w = NUM_WAYS - 2; w >= 0; w--) begin
      if (cnt_r[data_vic] > cnt_r[w]) begin
        data_vic = WAY_W'(w);
      end
    end
    victim = fetch_r ? fetch_vic : data_vic;
    sel    = hit ? hit_way : victim;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r  <= req_addr;
      fetch_r <= req_fetch;
      write_r <= req_write;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        tag_r[w]   <= reset_tag(w);
        cnt_r[w]   <= reset_count(w);
        dirty_r[w] <= 1'b1;
      end
    end else if (cmd.commit) begin
      if (hit) begin
        if (cnt_r[hit_way] != COUNT_MAX) begin
          cnt_r[hit_way] <= cnt_r[hit_way] + COUNT_ONE;
        end
        if (write_r) begin
          dirty_r[hit_way] <= 1'b1;
        end
      end else begin
        tag_r[victim]   <= blk;
        cnt_r[victim]   <= fetch_r ? COUNT_MAX : COUNT_ONE;
        dirty_r[victim] <= write_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit_r     <= hit;
      way_r     <= sel;
      off_r     <= addr_r[OFFSET_W-1:0];
      wb_need_r <= !hit && dirty_r[victim];
      wb_blk_r  <= (!hit && dirty_r[victim]) ? tag_r[victim] : '0;
    end
  end

  assign res_hit      = hit_r;
  assign res_way      = way_r;
  assign res_offset   = off_r;
  assign res_wb_need  = wb_need_r;
  assign res_wb_block = wb_blk_r;

`ifndef ASSERT_OFF
  a_miss_tag: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !hit |=> tag_r[way_r] == $past(blk))
    else $error("missed block not installed in chosen way");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && hit |=> !wb_need_r && wb_blk_r == '0)
    else $error("write-back reported on a hit");

  a_way_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> way_r <= WAY_W'(NUM_WAYS - 1))
    else $error("way out of range");

  a_fetch_pin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !hit && fetch_r |=> cnt_r[way_r] == COUNT_MAX)
    else $error("fetch fill not pinned");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bcd_ctrl.sv =====
`default_nettype none

module bcd_ctrl
  import bcd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output bcd_cmd_t  cmd
);

  bcd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    out_free   = !out_valid_r || out_ready;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.commit = out_free;
        if (out_free && !in_valid) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    in_ready      = (state_r == ST_IDLE) || cmd.commit;
    cmd.load      = in_valid && in_ready;
    out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !out_valid_r || out_ready)
    else $error("result overwritten before it was taken");

  a_load_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_LOOKUP)
    else $error("accepted item not looked up");
`endif

endmodule

`default_nettype wire

// ===== sim/block_cache_directory_tb.sv =====
typedef struct packed {
  logic                        hit;
  logic [bcd_pkg::WAY_W-1:0]   way;
  logic [bcd_pkg::OFFSET_W-1:0] offset_in_block;
  logic                        writeback_needed;
  logic [bcd_pkg::TAG_W-1:0]   writeback_block;
} lookup_t;

class lookup_tracker;
  logic [bcd_pkg::TAG_W-1:0]   tag_q   [bcd_pkg::NUM_WAYS];
  logic [bcd_pkg::COUNT_W-1:0] count_q [bcd_pkg::NUM_WAYS];
  logic                        dirty_q [bcd_pkg::NUM_WAYS];
  lookup_t                     expected_lookups [$];
  int unsigned                 errors;
  int unsigned                 checked;
  int unsigned                 hits;
  int unsigned                 writebacks;

  function new();
    for (int w = 0; w < bcd_pkg::NUM_WAYS; w++) begin
      case (w)
        0: begin
          tag_q[w]   = '0;
          count_q[w] = bcd_pkg::COUNT_MAX;
        end
        1: begin
          tag_q[w]   = bcd_pkg::TAG_W'(6552);
          count_q[w] = '0;
        end
        2: begin
          tag_q[w]   = bcd_pkg::TAG_W'(3011);
          count_q[w] = '0;
        end
        default: begin
          tag_q[w]   = '0;
          count_q[w] = '0;
        end
      endcase
      dirty_q[w] = 1'b1;
    end
    errors = 0;
    checked = 0;
    hits = 0;
    writebacks = 0;
  endfunction

  // lowest pinned way below the last, else the last
  function int unsigned fetch_victim();
    for (int w = 0; w < bcd_pkg::NUM_WAYS - 1; w++) begin
      if (count_q[w] == bcd_pkg::COUNT_MAX) return w;
    end
    return bcd_pkg::NUM_WAYS - 1;
  endfunction

  // smallest count, ties to the higher way
  function int unsigned data_victim();
    int unsigned best;
    best = bcd_pkg::NUM_WAYS - 1;
    for (int w = bcd_pkg::NUM_WAYS - 2; w >= 0; w--) begin
      if (count_q[best] > count_q[w]) best = w;
    end
    return best;
  endfunction

  function void note_request(input logic [bcd_pkg::ADDR_BITS-1:0] addr, input logic fetch,
                             input logic wr);
    logic [bcd_pkg::TAG_W-1:0] blk;
    lookup_t                   res;
    int unsigned               sel;
    bit                        found;
    blk   = addr[bcd_pkg::ADDR_BITS-1:bcd_pkg::OFFSET_W];
    found = 1'b0;
    sel   = 0;
    for (int w = 0; w < bcd_pkg::NUM_WAYS; w++) begin
      if (!found && tag_q[w] == blk) begin
        found = 1'b1;
        sel   = w;
      end
    end
    res = '0;
    res.hit = found;
    res.offset_in_block = addr[bcd_pkg::OFFSET_W-1:0];
    if (found) begin
      if (count_q[sel] != bcd_pkg::COUNT_MAX) count_q[sel] = count_q[sel] + 1'b1;
      if (wr) dirty_q[sel] = 1'b1;
    end else begin
      sel = fetch ? fetch_victim() : data_victim();
      if (dirty_q[sel]) begin
        res.writeback_needed = 1'b1;
        res.writeback_block  = tag_q[sel];
      end
      tag_q[sel]   = blk;
      count_q[sel] = fetch ? bcd_pkg::COUNT_MAX : bcd_pkg::COUNT_ONE;
      dirty_q[sel] = wr;
    end
    res.way = bcd_pkg::WAY_W'(sel);
    expected_lookups.push_back(res);
  endfunction

  function void compare_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(input logic [bcd_pkg::OUT_DATA_W-1:0] data,
                             input logic [bcd_pkg::OUT_USER_W-1:0] user);
    lookup_t exp_r;
    if (expected_lookups.size() == 0) begin
      $error("result item with no request outstanding: tdata %0h tuser %0h", data, user);
      errors++;
      return;
    end
    exp_r = expected_lookups.pop_front();
    checked++;
    if (exp_r.hit) hits++;
    if (exp_r.writeback_needed) writebacks++;
    compare_field("hit", exp_r.hit, user[0]);
    compare_field("writeback_needed", exp_r.writeback_needed, user[1]);
    compare_field("way", exp_r.way, data[bcd_pkg::WAY_W-1:0]);
    compare_field("offset_in_block", exp_r.offset_in_block,
                  data[bcd_pkg::WAY_W +: bcd_pkg::OFFSET_W]);
    compare_field("writeback_block", exp_r.writeback_block,
                  data[bcd_pkg::WAY_W + bcd_pkg::OFFSET_W +: bcd_pkg::TAG_W]);
  endfunction

  function int unsigned pending();
    return expected_lookups.size();
  endfunction
endclass

module block_cache_directory_tb;
  import bcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned POOL_SIZE    = 8;
  localparam int unsigned BOOT_TAG1    = 6552;
  localparam int unsigned BOOT_TAG2    = 3011;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  lookup_tracker         tracker;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           items_sent;
  int unsigned           stall_cycles;
  logic [TAG_W-1:0]      block_pool [POOL_SIZE];

  block_cache_directory u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_result(out_tdata, out_tuser);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_request(input logic [ADDR_BITS-1:0] addr, input logic fetch,
                              input logic wr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= {wr, fetch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_request(addr, fetch, wr);
    items_sent++;
    @(negedge clk);
  endtask

  // hold the input off until every lookup has come back
  task automatic wait_empty();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  task automatic refresh_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(5))
        0: block_pool[i] = TAG_W'(BOOT_TAG1);
        1: block_pool[i] = TAG_W'(BOOT_TAG2);
        2: block_pool[i] = $urandom_range(1) ? '1 : '0;
        default: block_pool[i] = TAG_W'($urandom);
      endcase
    end
  endtask

  task automatic run_random(input int unsigned n);
    logic [ADDR_BITS-1:0] addr;
    logic                 fetch;
    logic                 wr;
    int unsigned          pick;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 64 == 0) refresh_pool();
      if ($urandom_range(149) == 0) wait_empty();
      pick = $urandom_range(99);
      if (pick < 75) begin
        addr = {block_pool[$urandom_range(POOL_SIZE - 1)], OFFSET_W'($urandom)};
      end else if (pick < 80) begin
        addr = $urandom_range(1) ? '1 : '0;
      end else begin
        addr = ADDR_BITS'($urandom);
      end
      fetch = ($urandom_range(99) < 30);
      wr    = ($urandom_range(99) < 40);
      send_request(addr, fetch, wr);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    stall_cycles  = 0;
    items_sent    = 0;
    send_idle_pct = 6;
    recv_idle_pct = 45;
    tracker       = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // boot tags, pinned way, ties, dirty victims, address extremes
    send_request(24'h000000, 1'b0, 1'b0);
    send_request(ADDR_BITS'(BOOT_TAG1 * BLOCK_BYTES + 511), 1'b0, 1'b1);
    send_request(ADDR_BITS'(BOOT_TAG2 * BLOCK_BYTES + 5), 1'b1, 1'b0);
    send_request(24'hFFFFFF, 1'b0, 1'b0);
    send_request(24'h123456, 1'b1, 1'b0);
    send_request(24'hABCDEF, 1'b1, 1'b1);
    send_request(24'h000200, 1'b0, 1'b1);
    send_request(24'h000400, 1'b0, 1'b0);
    send_request(24'h000201, 1'b0, 1'b0);
    send_request(ADDR_BITS'(BOOT_TAG1 * BLOCK_BYTES), 1'b0, 1'b0);
    send_request(24'h800000, 1'b0, 1'b1);
    send_request(24'h7FFFFF, 1'b1, 1'b0);
    send_request(24'h000000, 1'b1, 1'b1);
    send_request(24'h5555AA, 1'b0, 1'b1);
    send_request(24'hAAAA55, 1'b0, 1'b0);
    send_request(24'hFFFE00, 1'b1, 1'b0);
    send_request(24'hFFFFFF, 1'b0, 1'b1);
    send_request(24'hFFFFFF, 1'b0, 1'b0);
    send_request(24'hABCDEF, 1'b0, 1'b0);
    send_request(24'h0001FF, 1'b1, 1'b1);
    wait_empty();

    run_random(620);
    wait_empty();
    send_idle_pct = 45;
    recv_idle_pct = 6;
    run_random(620);
    wait_empty();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(620);
    wait_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests, %0d results: %0d hits, %0d misses, %0d write-backs",
             items_sent, tracker.checked, tracker.hits, tracker.checked - tracker.hits,
             tracker.writebacks);
    $display("fetch and data misses, boot tags, address extremes, idle on both sides");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
